### sv/lsw_pkg.sv
`default_nettype none

package lsw_pkg;

    localparam int MAX_BEAMS   = 4096;
    localparam int TRIG_STAGES = 16;

    localparam int BI_W   = $clog2(MAX_BEAMS);
    localparam int STG_W  = $clog2(TRIG_STAGES);
    localparam int Q_DEPTH = 4;
    localparam int QP_W   = $clog2(Q_DEPTH);

    localparam logic [31:0] KINV_Q32 = 32'd2608131496;

    typedef enum logic [2:0] {
        CFG_MIN_RANGE = 3'd0,
        CFG_MAX_RANGE = 3'd1,
        CFG_START_ANG = 3'd2,
        CFG_ANG_STEP  = 3'd3,
        CFG_POSE_X    = 3'd4,
        CFG_POSE_Y    = 3'd5,
        CFG_HEADING   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        min_range;
        logic [15:0]        max_range;
        logic [31:0]        start_ang;
        logic [31:0]        ang_step;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic [31:0]        heading;
    } t_cfg;

    typedef struct packed {
        logic [31:0] theta;
        logic [31:0] x0;
        logic        ok;
        logic        last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROT,
        BK_DONE
    } t_bk_state;

    localparam logic signed [33:0] ATAN_TAB [32] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10680862, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81,
        34'sd41, 34'sd20, 34'sd10, 34'sd5,
        34'sd3, 34'sd1, 34'sd1, 34'sd0
    };

endpackage

`default_nettype wire

### sv/lsw_front.sv
`default_nettype none

module lsw_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lsw_pkg::t_cfg i_cfg,
    input  wire logic          i_accept,
    input  wire logic [15:0]   i_range,
    input  wire logic          i_range_bad,
    input  wire logic          i_last,
    output lsw_pkg::t_item     o_item
);

    logic [lsw_pkg::BI_W-1:0] r_idx;
    logic [lsw_pkg::BI_W-1:0] n_idx;
    logic [31:0]              w_idx_ext;
    logic [31:0]              w_prod;
    logic [47:0]              w_scaled;

    assign w_idx_ext = 32'(r_idx);
    assign w_prod    = w_idx_ext * i_cfg.ang_step;
    assign w_scaled  = 48'(i_range) * 48'(lsw_pkg::KINV_Q32);

    always_comb begin
        o_item.theta = i_cfg.start_ang + w_prod + i_cfg.heading;
        o_item.x0    = w_scaled[47:16];
        o_item.ok    = !i_range_bad && (i_range > i_cfg.min_range)
                       && (i_range < i_cfg.max_range);
        o_item.last  = i_last;
    end

    always_comb begin
        n_idx = r_idx;
        if (i_accept) begin
            if (i_last) begin
                n_idx = '0;
            end else if (r_idx != lsw_pkg::BI_W'(lsw_pkg::MAX_BEAMS - 1)) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

### sv/lsw_queue.sv
`default_nettype none

module lsw_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lsw_pkg::t_item i_item,
    input  wire logic           i_pop,
    output lsw_pkg::t_item      o_item,
    output lsw_pkg::t_q_stat    o_stat
);

    lsw_pkg::t_item r_mem [lsw_pkg::Q_DEPTH];

    logic [lsw_pkg::QP_W-1:0] r_wr;
    logic [lsw_pkg::QP_W-1:0] r_rd;
    logic [lsw_pkg::QP_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (lsw_pkg::QP_W + 1)'(lsw_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/lsw_back.sv
`default_nettype none

module lsw_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [23:0] i_pose_x,
    input  wire logic signed [23:0] i_pose_y,
    input  wire lsw_pkg::t_item     i_item,
    input  wire lsw_pkg::t_q_stat   i_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [47:0]             o_data,
    output logic                    o_user,
    output logic                    o_last
);

    lsw_pkg::t_bk_state r_state;
    lsw_pkg::t_bk_state n_state;

    logic signed [34:0]        r_x;
    logic signed [34:0]        r_y;
    logic signed [33:0]        r_z;
    logic [1:0]                r_quad;
    logic [lsw_pkg::STG_W-1:0] r_stage;
    logic                      r_ok;
    logic                      r_last;

    logic                      r_m_valid;
    logic [47:0]               r_m_data;
    logic                      r_m_user;
    logic                      r_m_last;

    logic [31:0]               w_q_sum;
    logic [1:0]                w_quad;
    logic [31:0]               w_resid;
    logic signed [34:0]        w_dx;
    logic signed [34:0]        w_dy;
    logic signed [33:0]        w_atan;
    logic signed [35:0]        w_fx;
    logic signed [35:0]        w_fy;
    logic                      w_load;
    logic                      w_emit;
    logic                      w_step;

    function automatic logic [23:0] finish(input logic signed [35:0] v,
                                           input logic signed [23:0] pose);
        logic signed [35:0] rnd;
        logic signed [35:0] sum;
        rnd = (v + 36'sd32768) >>> 16;
        sum = rnd + 36'(pose);
        if (sum > 36'sd8388607) begin
            finish = 24'h7F_FFFF;
        end else if (sum < -36'sd8388608) begin
            finish = 24'h80_0000;
        end else begin
            finish = sum[23:0];
        end
    endfunction

    assign w_q_sum = i_item.theta + 32'h2000_0000;
    assign w_quad  = w_q_sum[31:30];
    assign w_resid = i_item.theta - {w_quad, 30'd0};
    assign w_dx    = r_y >>> r_stage;
    assign w_dy    = r_x >>> r_stage;
    assign w_atan  = lsw_pkg::ATAN_TAB[5'(r_stage)];

    always_comb begin
        case (r_quad)
            2'd1:    begin w_fx = -36'(r_y); w_fy =  36'(r_x); end
            2'd2:    begin w_fx = -36'(r_x); w_fy = -36'(r_y); end
            2'd3:    begin w_fx =  36'(r_y); w_fy = -36'(r_x); end
            default: begin w_fx =  36'(r_x); w_fy =  36'(r_y); end
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        w_emit  = 1'b0;
        w_step  = 1'b0;
        case (r_state)
            lsw_pkg::BK_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop   = 1'b1;
                    w_load  = 1'b1;
                    n_state = i_item.ok ? lsw_pkg::BK_ROT : lsw_pkg::BK_DONE;
                end
            end
            lsw_pkg::BK_ROT: begin
                w_step = 1'b1;
                if (r_stage == lsw_pkg::STG_W'(lsw_pkg::TRIG_STAGES - 1)) begin
                    n_state = lsw_pkg::BK_DONE;
                end
            end
            lsw_pkg::BK_DONE: begin
                if (!r_m_valid || i_ready) begin
                    w_emit  = 1'b1;
                    n_state = lsw_pkg::BK_IDLE;
                end
            end
            default: n_state = lsw_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsw_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x     <= 35'(i_item.x0);
            r_y     <= '0;
            r_z     <= 34'(signed'(w_resid));
            r_quad  <= w_quad;
            r_stage <= '0;
            r_ok    <= i_item.ok;
            r_last  <= i_item.last;
        end else if (w_step) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
            r_stage <= r_stage + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit) begin
            r_m_valid <= 1'b1;
        end else if (i_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_ok) begin
                r_m_data <= {finish(w_fy, i_pose_y), finish(w_fx, i_pose_x)};
            end else begin
                r_m_data <= '0;
            end
            r_m_user <= r_ok;
            r_m_last <= r_last;
        end
    end

    assign o_valid = r_m_valid;
    assign o_data  = r_m_data;
    assign o_user  = r_m_user;
    assign o_last  = r_m_last;

endmodule

`default_nettype wire

### sv/laser_scan_to_world_points_top.sv
// Channel   Dir  Signals                        Contents (lowest bit up)
// s_axis    in   tvalid tready tdata tuser tlast range_mm | range_invalid | last_sample
// m_axis    out  tvalid tready tdata tuser tlast point_x_mm, point_y_mm | point_valid | last_point
// cfg       in   i_cfg_we i_cfg_addr i_cfg_wdata  register index 0..6, data up to 32 bits
//
// Front end (index, angle, range scaling) takes one sample per cycle while the
// 4-entry queue is not full. Back end runs one shared CORDIC stage per cycle for a
// valid sample and none for a rejected one; the queue absorbs bursts.
// Synchronous active-low reset clears index, queue, FSM and loads register defaults.
// Output register lets the back end finish while m_axis is stalled.
`default_nettype none

module laser_scan_to_world_points_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] range_mm
    input  wire logic [0:0]  s_axis_tuser,  // [0] range_invalid
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [23:0] point_x_mm, [47:24] point_y_mm
    output logic [0:0]       m_axis_tuser,  // [0] point_valid
    output logic             m_axis_tlast
);

    lsw_pkg::t_cfg    r_cfg;
    lsw_pkg::t_item   w_front_item;
    lsw_pkg::t_item   w_head_item;
    lsw_pkg::t_q_stat w_stat;
    logic             w_push;
    logic             w_pop;
    logic             w_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_range <= 16'd0;
            r_cfg.max_range <= 16'hFFFF;
            r_cfg.start_ang <= '0;
            r_cfg.ang_step  <= '0;
            r_cfg.pose_x    <= '0;
            r_cfg.pose_y    <= '0;
            r_cfg.heading   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lsw_pkg::CFG_MIN_RANGE: r_cfg.min_range <= i_cfg_wdata[15:0];
                lsw_pkg::CFG_MAX_RANGE: r_cfg.max_range <= i_cfg_wdata[15:0];
                lsw_pkg::CFG_START_ANG: r_cfg.start_ang <= i_cfg_wdata;
                lsw_pkg::CFG_ANG_STEP:  r_cfg.ang_step  <= i_cfg_wdata;
                lsw_pkg::CFG_POSE_X:    r_cfg.pose_x    <= i_cfg_wdata[23:0];
                lsw_pkg::CFG_POSE_Y:    r_cfg.pose_y    <= i_cfg_wdata[23:0];
                lsw_pkg::CFG_HEADING:   r_cfg.heading   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_stat.full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    lsw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_push),
        .i_range     (s_axis_tdata),
        .i_range_bad (s_axis_tuser[0]),
        .i_last      (s_axis_tlast),
        .o_item      (w_front_item)
    );

    lsw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_stat)
    );

    lsw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pose_x (r_cfg.pose_x),
        .i_pose_y (r_cfg.pose_y),
        .i_item   (w_head_item),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (w_user),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tuser = w_user;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("queue pop while empty");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 48'd0))
        else $error("rejected sample carries non-zero coordinates");

    a_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && w_stat.empty) |=> !w_stat.empty)
        else $error("accepted transaction lost in queue");
`endif

endmodule

`default_nettype wire

### verif/tb_laser_scan_to_world_points_top.sv
`default_nettype none

module tb_laser_scan_to_world_points_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsw_pkg::*;

    localparam int     TAIL_CYCLES = 4 * (TRIG_STAGES + 2);
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam longint KINV_SCALE  = 64'd2608131496;
    localparam logic [2:0] CFG_NONE = 3'd7;

    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    localparam longint ATAN_BAM [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               valid;
        logic               last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_cfg            shadow_cfg;
    logic [BI_W-1:0] beam_idx;
    t_point          expected_points[$];
    int unsigned     mismatch_count = 0;
    longint          cycle_count = 0;
    bit              idle_on = 1'b0;

    laser_scan_to_world_points_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("laser_scan_to_world_points_top verification failed");
            $finish;
        end
    end

    function automatic logic signed [23:0] round_sat(longint v, logic signed [23:0] pose);
        longint s;
        s = ((v + 32768) >>> 16) + longint'(pose);
        if (s > 64'sd8388607)
            s = 64'sd8388607;
        if (s < -64'sd8388608)
            s = -64'sd8388608;
        return 24'(s);
    endfunction

    function automatic t_point world_point(logic [15:0] rng, logic bad, logic last);
        t_point      p;
        logic [31:0] theta;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy, fx, fy;
        p.x = '0;
        p.y = '0;
        p.last = last;
        p.valid = !bad && rng > shadow_cfg.min_range && rng < shadow_cfg.max_range;
        if (p.valid) begin
            theta = shadow_cfg.start_ang + 32'(beam_idx) * shadow_cfg.ang_step
                    + shadow_cfg.heading;
            quad = 2'((theta + 32'h2000_0000) >> 30);
            resid = theta - {quad, 30'd0};
            z = longint'($signed(resid));
            x = (longint'(rng) * KINV_SCALE) >>> 16;
            y = 0;
            for (int i = 0; i < TRIG_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_BAM[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_BAM[i];
                end
            end
            case (quad)
                QUAD_90: begin
                    fx = -y;
                    fy = x;
                end
                QUAD_180: begin
                    fx = -x;
                    fy = -y;
                end
                QUAD_270: begin
                    fx = y;
                    fy = -x;
                end
                default: begin
                    fx = x;
                    fy = y;
                end
            endcase
            p.x = round_sat(fx, shadow_cfg.pose_x);
            p.y = round_sat(fy, shadow_cfg.pose_y);
        end
        return p;
    endfunction

    function automatic logic [31:0] corner_or_any(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] rng, input logic bad, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rng;
        s_axis_tuser <= bad;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_points.insert(expected_points.size(), world_point(rng, bad, last));
        if (last)
            beam_idx = '0;
        else if (beam_idx != BI_W'(MAX_BEAMS - 1))
            beam_idx = beam_idx + 1'b1;
    endtask

    // block must be empty before any register write
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_RANGE: shadow_cfg.min_range = val[15:0];
            CFG_MAX_RANGE: shadow_cfg.max_range = val[15:0];
            CFG_START_ANG: shadow_cfg.start_ang = val;
            CFG_ANG_STEP:  shadow_cfg.ang_step = val;
            CFG_POSE_X:    shadow_cfg.pose_x = val[23:0];
            CFG_POSE_Y:    shadow_cfg.pose_y = val[23:0];
            CFG_HEADING:   shadow_cfg.heading = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] min_r, input logic [15:0] max_r,
                              input logic [31:0] start, input logic [31:0] step,
                              input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] hd);
        write_reg(CFG_MIN_RANGE, 32'(min_r));
        write_reg(CFG_MAX_RANGE, 32'(max_r));
        write_reg(CFG_START_ANG, start);
        write_reg(CFG_ANG_STEP, step);
        write_reg(CFG_POSE_X, px);
        write_reg(CFG_POSE_Y, py);
        write_reg(CFG_HEADING, hd);
    endtask

    task automatic test_reset_values();
        idle_on = 1'b0;
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'd1, 1'b0, 1'b0);
        send_sample(16'd65534, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd1234, 1'b1, 1'b0);
        send_sample(16'd1234, 1'b0, 1'b1);
    endtask

    task automatic test_quadrants();
        logic [31:0] headings [8];
        headings = '{32'h0000_0000, 32'h1FFF_FFFF, 32'h2000_0000, 32'h4000_0000,
                     32'h8000_0000, 32'hC000_0000, 32'hE000_0000, 32'hFFFF_FFFF};
        idle_on = 1'b1;
        foreach (headings[k]) begin
            wait_idle();
            write_reg(CFG_HEADING, headings[k]);
            send_sample(16'd3000, 1'b0, 1'b1);
        end
    endtask

    task automatic test_range_window();
        wait_idle();
        set_config(16'd100, 16'd200, 32'h1000_0000, 32'h0100_0000,
                   32'hFFFF_FC18, 32'd2500, 32'h0);
        send_sample(16'd100, 1'b0, 1'b0);
        send_sample(16'd101, 1'b0, 1'b0);
        send_sample(16'd199, 1'b0, 1'b0);
        send_sample(16'd200, 1'b0, 1'b1);
        wait_idle();
        write_reg(CFG_MIN_RANGE, 32'h0000_FFFF);
        write_reg(CFG_MAX_RANGE, 32'h0);
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b1);
    endtask

    task automatic test_saturation();
        wait_idle();
        set_config(16'd0, 16'hFFFF, 32'h0, 32'h0, 32'h007F_FFFF, 32'h0080_0000,
                   32'hE000_0000);
        send_sample(16'd65534, 1'b0, 1'b1);
        wait_idle();
        write_reg(CFG_POSE_X, 32'h0080_0000);
        write_reg(CFG_POSE_Y, 32'h007F_FFFF);
        write_reg(CFG_HEADING, 32'h6000_0000);
        send_sample(16'd65534, 1'b0, 1'b1);
    endtask

    task automatic test_unknown_register();
        wait_idle();
        write_reg(CFG_NONE, $urandom());
        write_reg(CFG_POSE_X, 32'hFF00_0123);
        send_sample(16'd5000, 1'b0, 1'b1);
    endtask

    // rejected samples keep the index moving cheaply up to saturation
    task automatic test_index_overflow();
        logic use_it;
        wait_idle();
        set_config(16'd0, 16'hFFFF, 32'h0800_0000, 32'h0012_3457, 32'h0, 32'h0, 32'h0);
        idle_on = 1'b0;
        for (int k = 0; k < MAX_BEAMS + 4; k++) begin
            use_it = (k < 3) || (k >= MAX_BEAMS - 3);
            send_sample(16'd20000, !use_it, 1'b0);
        end
        send_sample(16'd20000, 1'b0, 1'b1);
        send_sample(16'd20000, 1'b0, 1'b0);
    endtask

    task automatic test_random_scans();
        logic [15:0] min_r, max_r, rng;
        logic        bad, last, broken;
        int          sent, scan_len;
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0: min_r = 16'd0;
                1: min_r = 16'hFFFF;
                default: min_r = 16'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 7))
                0: max_r = 16'd0;
                1: max_r = 16'hFFFF;
                default: max_r = 16'($urandom_range(min_r, 65535));
            endcase
            set_config(min_r, max_r,
                       corner_or_any(32'h0, 32'hFFFF_FFFF),
                       corner_or_any(32'h0, 32'hFFFF_FFFF),
                       corner_or_any(32'h007F_FFFF, 32'h0080_0000),
                       corner_or_any(32'h007F_FFFF, 32'h0080_0000),
                       corner_or_any(32'h0, 32'hFFFF_FFFF));
            idle_on = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 50) begin
                scan_len = $urandom_range(1, 40);
                broken = ($urandom_range(0, 9) == 0);
                for (int j = 0; j < scan_len && sent < 50; j++) begin
                    if ($urandom_range(0, 3) != 0)
                        rng = 16'($urandom_range(min_r, max_r));
                    else
                        rng = 16'($urandom_range(0, 65535));
                    bad = ($urandom_range(0, 9) == 0);
                    last = broken ? ($urandom_range(0, 7) == 0) : (j == scan_len - 1);
                    send_sample(rng, bad, last);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int     stall;
        t_point want, got;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 15) : 0;
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            got.x = m_axis_tdata[23:0];
            got.y = m_axis_tdata[47:24];
            got.valid = m_axis_tuser[0];
            got.last = m_axis_tlast;
            if (expected_points.size() == 0) begin
                $error("unexpected transaction: x=%0d y=%0d valid=%0b last=%0b",
                       got.x, got.y, got.valid, got.last);
                mismatch_count++;
            end else begin
                want = expected_points.pop_front();
                if (got.x !== want.x) begin
                    $error("point_x_mm expected %0d got %0d", want.x, got.x);
                    mismatch_count++;
                end
                if (got.y !== want.y) begin
                    $error("point_y_mm expected %0d got %0d", want.y, got.y);
                    mismatch_count++;
                end
                if (got.valid !== want.valid) begin
                    $error("point_valid expected %0b got %0b", want.valid, got.valid);
                    mismatch_count++;
                end
                if (got.last !== want.last) begin
                    $error("last_point expected %0b got %0b", want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        shadow_cfg.min_range = 16'd0;
        shadow_cfg.max_range = 16'hFFFF;
        shadow_cfg.start_ang = 32'h0;
        shadow_cfg.ang_step = 32'h0;
        shadow_cfg.pose_x = 24'sd0;
        shadow_cfg.pose_y = 24'sd0;
        shadow_cfg.heading = 32'h0;
        beam_idx = '0;
        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_quadrants();
        test_range_window();
        test_saturation();
        test_unknown_register();
        test_index_overflow();
        test_random_scans();
        wait_idle();
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("laser_scan_to_world_points_top verification clean");
        else
            $display("laser_scan_to_world_points_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
sv/lsw_pkg.sv
sv/lsw_front.sv
sv/lsw_queue.sv
sv/lsw_back.sv
sv/laser_scan_to_world_points_top.sv
verif/tb_laser_scan_to_world_points_top.sv
